[sv/oct_pkg.sv]
// Shared types and constants for the octahedral normal encoder.
// No dependencies; every file but oct_if refers to it by scoped names.
package oct_pkg;

	// snorm16 full-scale value
	localparam logic [15:0] SNORM_SCALE = 16'd32767;
	// quotient bits per coordinate (magnitude never exceeds SNORM_SCALE)
	localparam int Q_W = 15;
	// one output half
	localparam int HALF_W = 16;
	localparam int WORD_W = 2 * HALF_W;

	typedef struct packed {
		logic neg_u;
		logic neg_v;
		logic zero;
	} flags_t;

endpackage

[sv/oct_if.sv]
// Valid/ready channel interfaces for the encoder: normal vector in, packed word out.
// Depends on nothing; the component width is an interface parameter.
interface oct_in_if #(
	parameter int COMPONENT_WIDTH = 16
);
	logic                              valid;
	logic                              ready;
	logic signed [COMPONENT_WIDTH-1:0] normal_x;
	logic signed [COMPONENT_WIDTH-1:0] normal_y;
	logic signed [COMPONENT_WIDTH-1:0] normal_z;

	modport source (output valid, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface oct_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] oct_word;

	modport source (output valid, oct_word, input ready);
	modport sink (input valid, oct_word, output ready);
endinterface

[sv/oct_front.sv]
// Front stage: magnitudes, L1 norm, hemisphere fold and dividend/divisor setup.
// Uses oct_pkg; feeds the first divider cell.
module oct_front #(
	parameter int CW = 16,
	parameter int NW = CW + 17,
	parameter int DW = CW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic [CW-1:0]        x,
	input  logic [CW-1:0]        y,
	input  logic [CW-1:0]        z,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output logic [NW-1:0]        n_u,
	output logic [NW-1:0]        n_v,
	output logic [DW-1:0]        d,
	output oct_pkg::flags_t      flags
);
	localparam int LW = CW + 1;

	logic [CW-1:0]   ax, ay, az;
	logic [LW-1:0]   l1, mu, mv;
	oct_pkg::flags_t fl;
	logic            v_s1;
	logic [LW-1:0]   l1_s1, mu_s1, mv_s1;
	oct_pkg::flags_t fl_s1;

	always_comb begin
		ax = x[CW-1] ? (~x + 1'b1) : x;
		ay = y[CW-1] ? (~y + 1'b1) : y;
		az = z[CW-1] ? (~z + 1'b1) : z;
		l1 = LW'(ax) + LW'(ay) + LW'(az);
		// lower hemisphere folds onto the upper square
		if (z[CW-1]) begin
			mu = l1 - LW'(ay);
			mv = l1 - LW'(ax);
		end else begin
			mu = LW'(ax);
			mv = LW'(ay);
		end
		fl.neg_u = x[CW-1];
		fl.neg_v = y[CW-1];
		fl.zero  = (l1 == '0);
	end

	assign up_ready = !v_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			l1_s1 <= l1;
			mu_s1 <= mu;
			mv_s1 <= mv;
			fl_s1 <= fl;
		end
	end

	// q = floor((2*S*m + L1) / (2*L1))
	assign n_u      = NW'(mu_s1) * NW'({oct_pkg::SNORM_SCALE, 1'b0}) + NW'(l1_s1);
	assign n_v      = NW'(mv_s1) * NW'({oct_pkg::SNORM_SCALE, 1'b0}) + NW'(l1_s1);
	assign d        = {l1_s1, 1'b0};
	assign dn_valid = v_s1;
	assign flags    = fl_s1;

	a_fold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (mu_s1 <= l1_s1) && (mv_s1 <= l1_s1))
		else $error("folded coordinate exceeds L1");
endmodule

[sv/oct_div_cell.sv]
// One restoring-division cell: settles quotient bit BIT of both coordinates.
// Uses oct_pkg; cells are chained in the top level.
module oct_div_cell #(
	parameter int RW  = 33,
	parameter int DW  = 18,
	parameter int BIT = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [RW-1:0]              r_u,
	input  logic [RW-1:0]              r_v,
	input  logic [DW-1:0]              d,
	input  logic [oct_pkg::Q_W-1:0]    q_u,
	input  logic [oct_pkg::Q_W-1:0]    q_v,
	input  oct_pkg::flags_t            flags,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output logic [RW-1:0]              r_u_o,
	output logic [RW-1:0]              r_v_o,
	output logic [DW-1:0]              d_o,
	output logic [oct_pkg::Q_W-1:0]    q_u_o,
	output logic [oct_pkg::Q_W-1:0]    q_v_o,
	output oct_pkg::flags_t            flags_o
);
	logic [RW-1:0]           dsh, dsh_q;
	logic                    ge_u, ge_v;
	logic [RW-1:0]           r_u_n, r_v_n;
	logic [oct_pkg::Q_W-1:0] q_u_n, q_v_n;
	logic                    v_q;
	logic [RW-1:0]           r_u_q, r_v_q;
	logic [DW-1:0]           d_q;
	logic [oct_pkg::Q_W-1:0] q_u_q, q_v_q;
	oct_pkg::flags_t         flags_q;

	assign dsh = RW'(d) << BIT;

	always_comb begin
		ge_u  = (r_u >= dsh);
		ge_v  = (r_v >= dsh);
		r_u_n = ge_u ? (r_u - dsh) : r_u;
		r_v_n = ge_v ? (r_v - dsh) : r_v;
		q_u_n = q_u;
		q_v_n = q_v;
		q_u_n[BIT] = ge_u;
		q_v_n[BIT] = ge_v;
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			r_u_q   <= r_u_n;
			r_v_q   <= r_v_n;
			d_q     <= d;
			q_u_q   <= q_u_n;
			q_v_q   <= q_v_n;
			flags_q <= flags;
		end
	end

	assign dn_valid = v_q;
	assign r_u_o    = r_u_q;
	assign r_v_o    = r_v_q;
	assign d_o      = d_q;
	assign q_u_o    = q_u_q;
	assign q_v_o    = q_v_q;
	assign flags_o  = flags_q;

	assign dsh_q = RW'(d_q) << BIT;

	// remainder must end below the divisor weight of this bit
	a_rem_u: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !flags_q.zero) |-> (r_u_q < dsh_q))
		else $error("u remainder out of range");
	a_rem_v: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !flags_q.zero) |-> (r_v_q < dsh_q))
		else $error("v remainder out of range");
endmodule

[sv/oct_pack.sv]
// Output stage: applies signs, zero-vector override and packs the snorm16 pair.
// Uses oct_pkg and oct_out_if.
module oct_pack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [oct_pkg::Q_W-1:0] q_u,
	input  logic [oct_pkg::Q_W-1:0] q_v,
	input  oct_pkg::flags_t         flags,
	oct_out_if.source               oct_out
);
	logic [oct_pkg::HALF_W-1:0] h_u, h_v;
	logic                       v_q;
	logic [oct_pkg::WORD_W-1:0] word_q;

	always_comb begin
		h_u = oct_pkg::HALF_W'(q_u);
		h_v = oct_pkg::HALF_W'(q_v);
		if (flags.neg_u) begin
			h_u = ~h_u + 1'b1;
		end
		if (flags.neg_v) begin
			h_v = ~h_v + 1'b1;
		end
		if (flags.zero) begin
			h_u = '0;
			h_v = '0;
		end
	end

	assign up_ready = !v_q || oct_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= {h_v, h_u};
		end
	end

	assign oct_out.valid    = v_q;
	assign oct_out.oct_word = word_q;

	// magnitude is at most 32767, so the most negative code never shows up
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> (word_q[15:0] != 16'h8000) && (word_q[31:16] != 16'h8000))
		else $error("snorm half out of range");
endmodule

[sv/octahedral_normal_encoder_top.sv]
// Octahedral normal encoder: one signed (x, y, z) vector in, one packed snorm16
// pair out per beat. Takes one beat every clock cycle when the output is drained;
// the pipeline is a front stage (magnitudes, L1, fold, dividend), a row of 15
// restoring-division cells each settling one quotient bit of both coordinates,
// and a registered output stage. Every stage has its own valid bit, so bubbles
// close up while the output stalls. Zero vector yields 0.
// Depends on oct_pkg, oct_if, oct_front, oct_div_cell and oct_pack.
module octahedral_normal_encoder_top #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	oct_in_if.sink    normal_in,
	oct_out_if.source oct_out
);
	localparam int CW = COMPONENT_WIDTH;
	localparam int RW = CW + 17;
	localparam int DW = CW + 2;
	localparam int QW = oct_pkg::Q_W;

	logic                    c_valid [0:QW];
	logic                    c_ready [0:QW];
	logic [RW-1:0]           r_u     [0:QW];
	logic [RW-1:0]           r_v     [0:QW];
	logic [DW-1:0]           d       [0:QW];
	logic [QW-1:0]           q_u     [0:QW];
	logic [QW-1:0]           q_v     [0:QW];
	oct_pkg::flags_t         flags   [0:QW];

	oct_front #(
		.CW (CW),
		.NW (RW),
		.DW (DW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (normal_in.valid),
		.up_ready (normal_in.ready),
		.x        (normal_in.normal_x),
		.y        (normal_in.normal_y),
		.z        (normal_in.normal_z),
		.dn_valid (c_valid[0]),
		.dn_ready (c_ready[0]),
		.n_u      (r_u[0]),
		.n_v      (r_v[0]),
		.d        (d[0]),
		.flags    (flags[0])
	);

	assign q_u[0] = '0;
	assign q_v[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		oct_div_cell #(
			.RW  (RW),
			.DW  (DW),
			.BIT (QW - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[k]),
			.up_ready (c_ready[k]),
			.r_u      (r_u[k]),
			.r_v      (r_v[k]),
			.d        (d[k]),
			.q_u      (q_u[k]),
			.q_v      (q_v[k]),
			.flags    (flags[k]),
			.dn_valid (c_valid[k+1]),
			.dn_ready (c_ready[k+1]),
			.r_u_o    (r_u[k+1]),
			.r_v_o    (r_v[k+1]),
			.d_o      (d[k+1]),
			.q_u_o    (q_u[k+1]),
			.q_v_o    (q_v[k+1]),
			.flags_o  (flags[k+1])
		);
	end

	oct_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid[QW]),
		.up_ready (c_ready[QW]),
		.q_u      (q_u[QW]),
		.q_v      (q_v[QW]),
		.flags    (flags[QW]),
		.oct_out  (oct_out)
	);
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for octahedral_normal_encoder_top: random and corner normal vectors
// in, packed snorm16 pair words out, checked against an in-bench exact-rational predictor.
// Depends on oct_pkg, oct_if and the encoder RTL.
module testbench;

	localparam int COMP_W       = 16;
	localparam int RANDOM_ITEMS = 1150;
	localparam int DRAIN_CYCLES = 40;

	typedef logic [oct_pkg::WORD_W-1:0] oct_word_t;

	typedef struct {
		int        x;
		int        y;
		int        z;
		oct_word_t word;
	} expected_word_t;

	class octahedral_checker;
		expected_word_t expected_words[$];
		int errors;
		int vectors;
		int compared;

		function new();
			errors   = 0;
			vectors  = 0;
			compared = 0;
		endfunction

		// round(scale * mag / l1), ties away from zero, then signed
		function logic [15:0] snorm_round(longint mag, bit neg, longint l1);
			longint q;
			q = (2 * longint'(oct_pkg::SNORM_SCALE) * mag + l1) / (2 * l1);
			if (neg)
				q = -q;
			return q[15:0];
		endfunction

		function oct_word_t encode_normal(int x, int y, int z);
			longint ax, ay, az, l1, mu, mv;
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			az = (z < 0) ? -z : z;
			l1 = ax + ay + az;
			if (l1 == 0)
				return '0;
			// lower hemisphere folds onto the upper square; signs keep zero as positive
			if (z < 0) begin
				mu = l1 - ay;
				mv = l1 - ax;
			end else begin
				mu = ax;
				mv = ay;
			end
			return {snorm_round(mv, y < 0, l1), snorm_round(mu, x < 0, l1)};
		endfunction

		function void note_vector(int x, int y, int z);
			expected_word_t e;
			e.x    = x;
			e.y    = y;
			e.z    = z;
			e.word = encode_normal(x, y, z);
			expected_words.push_back(e);
			vectors++;
		endfunction

		function void check_word(oct_word_t actual);
			expected_word_t e;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected output beat: expected none actual %h", $time, actual);
				errors++;
				return;
			end
			e = expected_words.pop_front();
			compared++;
			if (actual !== e.word) begin
				$display("%0t: oct_word mismatch for (%0d, %0d, %0d): expected %h actual %h",
					$time, e.x, e.y, e.z, e.word, actual);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void close();
			if (expected_words.size() != 0) begin
				$display("%0t: %0d expected words never arrived: expected %h actual none",
					$time, expected_words.size(), expected_words[0].word);
				errors += expected_words.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	octahedral_checker encoder_model;

	oct_in_if #(.COMPONENT_WIDTH(COMP_W)) in_if ();
	oct_out_if                            out_if ();

	octahedral_normal_encoder_top #(
		.COMPONENT_WIDTH(COMP_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.normal_in(in_if),
		.oct_out  (out_if)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// beat monitor: inputs feed the predictor, outputs get checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				encoder_model.note_vector(int'(in_if.normal_x), int'(in_if.normal_y),
					int'(in_if.normal_z));
			if (out_if.valid && out_if.ready)
				encoder_model.check_word(out_if.oct_word);
		end
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_vector(input int x, input int y, input int z);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid    <= 1'b1;
		in_if.normal_x <= x[COMP_W-1:0];
		in_if.normal_y <= y[COMP_W-1:0];
		in_if.normal_z <= z[COMP_W-1:0];
		do
			@(posedge clk);
		while (!in_if.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (encoder_model.pending() != 0)
			@(negedge clk);
	endtask

	function automatic int random_component();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 65535)) - 32768;
			1: return int'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return int'($urandom_range(0, 4000)) - 2000;
		endcase
	endfunction

	task automatic send_random(input int count);
		repeat (count)
			send_vector(random_component(), random_component(), random_component());
	endtask

	initial begin
		encoder_model = new();
		send_idle_pct = 22;
		recv_idle_pct = 57;
		arst_n          = 1'b0;
		in_if.valid     = 1'b0;
		in_if.normal_x  = '0;
		in_if.normal_y  = '0;
		in_if.normal_z  = '0;
		out_if.ready    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners: zero vector, axis extremes, folds on each axis, ties, z at zero
		send_vector(0, 0, 0);
		send_vector(32767, 0, 0);
		send_vector(-32768, 0, 0);
		send_vector(0, 32767, 0);
		send_vector(0, -32768, 0);
		send_vector(0, 0, 32767);
		send_vector(0, 0, -32768);
		send_vector(-1, 0, 0);
		send_vector(32767, 32767, 32767);
		send_vector(-32768, -32768, -32768);
		send_vector(-32768, -32768, 32767);
		send_vector(32767, -32768, -32768);
		send_vector(1, -1, 0);
		send_vector(-1, 1, 0);
		send_vector(1, 1, 1);
		send_vector(-1, 32767, 32767);
		send_vector(0, -5, -3);
		send_vector(-5, 0, -3);
		send_vector(3, 5, -1);
		send_vector(-3, -5, -1);
		send_vector(1, 0, -1);
		send_vector(-32768, 32767, -1);

		send_random(RANDOM_ITEMS / 3);
		wait_drained();

		send_idle_pct = 57;
		recv_idle_pct = 22;
		send_random(RANDOM_ITEMS / 3);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		encoder_model.close();
		$display("Encoded %0d normal vectors and compared %0d packed words", encoder_model.vectors,
			encoder_model.compared);
		$display("over corner cases and three pacing phases of sender and receiver stalls.");
		if (encoder_model.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#400000;
		$display("Timeout with %0d words outstanding", encoder_model.pending());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[octahedral_normal_encoder_top.f]
sv/oct_pkg.sv
sv/oct_if.sv
sv/oct_front.sv
sv/oct_div_cell.sv
sv/oct_pack.sv
sv/octahedral_normal_encoder_top.sv
tb/sv/testbench.sv
